@@ hdl/nrdc_pkg.sv @@
package nrdc_pkg;

    // Time constants
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MINUTE    = 59;

    // Field widths
    localparam int TS_W      = 64;
    localparam int REM_W     = 17;
    localparam int CHARS_W   = 32;
    localparam int IVL_W     = 16;
    localparam int ISEC_W    = 22;
    localparam int CFG_IDX_W = 2;

    // Day modulo split: 86400 = 2^7 * 675
    localparam int LOW_BITS = 7;
    localparam int DAY_ODD  = SECS_PER_DAY >> LOW_BITS;
    localparam int ODD_W    = 10;
    localparam int NBYTES   = 7;
    localparam int PROD_W   = 18;
    localparam int SUM_W    = 21;
    localparam int Q_W      = 11;

    // Reciprocal of 675 scaled by 2^32, rounded up; exact for sums below 2^21
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 23;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + DAY_ODD - 1) / DAY_ODD;

    // Divider iterations: one quotient bit per stage over the 17-bit offset
    localparam int DIV_STAGES = REM_W;

    // Weight of byte j of the high part, i.e. 2^(8j) mod 675
    function automatic int byte_weight(input int j);
        int w;
        w = 1;
        for (int k = 0; k < j; k++)
        begin
            w = (w * 256) % DAY_ODD;
        end
        return w;
    endfunction

    localparam int BYTE_WEIGHT [NBYTES] = '{
        byte_weight(0), byte_weight(1), byte_weight(2), byte_weight(3),
        byte_weight(4), byte_weight(5), byte_weight(6)
    };

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_START_TIME = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_INTERVAL   = cfg_idx_t'(1);

    // Reset values
    localparam logic [CHARS_W-1:0] START_RESET = 32'h3030_3030;
    localparam logic [IVL_W-1:0]   IVL_RESET   = 16'd1;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

endpackage

@@ hdl/nrdc_req_if.sv @@
interface nrdc_req_if;
    import nrdc_pkg::*;

    logic            valid;
    logic            ready;
    logic [TS_W-1:0] ts_secs;

    modport source (output valid, output ts_secs, input ready);
    modport sink (input valid, input ts_secs, output ready);
endinterface

@@ hdl/nrdc_rsp_if.sv @@
interface nrdc_rsp_if;
    import nrdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [REM_W-1:0] delay_secs;
    logic             error;

    modport source (output valid, output delay_secs, output error, input ready);
    modport sink (input valid, input delay_secs, input error, output ready);
endinterface

@@ hdl/nrdc_cfg_if.sv @@
interface nrdc_cfg_if;
    import nrdc_pkg::*;

    logic               valid;
    logic               ready;
    cfg_idx_t           index;
    logic [CHARS_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/next_report_delay_calc.sv @@
// Throughput: one request per cycle; a stalled output freezes the whole pipeline.
// Stages: five front stages (day reduction, offset), the 17-stage one-bit-per-stage
// remainder unit and the output register; the first stage loads at the accept edge.
// Reset (rst_n low, async): pipeline emptied, start time "0000", interval 1 minute.
module next_report_delay_calc (
    input  logic   clk,
    input  logic   rst_n,
    nrdc_cfg_if.sink   cfg,
    nrdc_req_if.sink   req,
    nrdc_rsp_if.source rsp
);
    import nrdc_pkg::*;

    // Configuration registers
    logic [CHARS_W-1:0] start_reg;
    logic [IVL_W-1:0]   ivl_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RESET;
            ivl_reg   <= IVL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_START_TIME: start_reg <= cfg.data;
                CFG_INTERVAL:   ivl_reg   <= cfg.data[IVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Derived schedule values
    logic [3:0]        dig [4];
    logic              bad_char;
    logic [6:0]        hour;
    logic [6:0]        minute;
    logic [REM_W-1:0]  base_next;
    logic [ISEC_W-1:0] isec_next;
    logic              cfg_err_next;
    logic [REM_W-1:0]  base_reg;
    logic [ISEC_W-1:0] isec_reg;
    logic              cfg_err_reg;

    always_comb
    begin
        bad_char = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            dig[i] = start_reg[8*(3-i) +: 4];
            if (start_reg[8*(3-i) +: 8] < ASCII_ZERO || start_reg[8*(3-i) +: 8] > ASCII_NINE)
            begin
                bad_char = 1'b1;
            end
        end
        hour   = 7'(dig[0] * 7'd10) + 7'(dig[1]);
        minute = 7'(dig[2] * 7'd10) + 7'(dig[3]);
        base_next = REM_W'(hour * REM_W'(SECS_PER_HOUR))
                  + REM_W'(minute * REM_W'(SECS_PER_MIN));
        isec_next = ISEC_W'(ivl_reg * ISEC_W'(SECS_PER_MIN));
        cfg_err_next = bad_char || (ivl_reg == '0)
                     || (hour > 7'(MAX_HOUR)) || (minute > 7'(MAX_MINUTE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            isec_reg    <= ISEC_W'(SECS_PER_MIN);
            cfg_err_reg <= 1'b0;
        end
        else
        begin
            base_reg    <= base_next;
            isec_reg    <= isec_next;
            cfg_err_reg <= cfg_err_next;
        end
    end

    // Pipeline advance: the whole pipeline moves while the output register is empty or taken
    logic adv;
    logic ov_reg;
    assign adv       = !ov_reg || rsp.ready;
    assign req.ready = adv;

    // Stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic dv_reg [DIV_STAGES];

    // Stage payloads
    logic                err1_reg, err2_reg, err3_reg, err4_reg, err5_reg;
    logic [LOW_BITS-1:0] lo1_reg, lo2_reg, lo3_reg;
    logic [PROD_W-1:0]   prod1_reg [NBYTES];
    logic [SUM_W-1:0]    sum2_reg, sum3_reg;
    logic [Q_W-1:0]      q3_reg;
    logic [REM_W-1:0]    cur4_reg, cur5_reg;
    logic                before5_reg;
    logic [REM_W-1:0]    d5_reg;

    logic                derr_reg    [DIV_STAGES];
    logic [REM_W-1:0]    dcur_reg    [DIV_STAGES];
    logic                dbefore_reg [DIV_STAGES];
    logic [REM_W-1:0]    dd_reg      [DIV_STAGES];
    logic [ISEC_W-1:0]   dr_reg      [DIV_STAGES];

    logic [REM_W-1:0]    orem_reg;
    logic                oerr_reg;

    // Stage 1: per-byte weighted residues of the timestamp high part
    logic [PROD_W-1:0] prod_next [NBYTES];
    always_comb
    begin
        for (int j = 0; j < NBYTES; j++)
        begin
            prod_next[j] = PROD_W'(req.ts_secs[LOW_BITS + 8*j +: 8])
                         * PROD_W'(BYTE_WEIGHT[j]);
        end
    end

    // Stage 2: sum of residues
    logic [SUM_W-1:0] sum_next;
    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < NBYTES; j++)
        begin
            sum_next = sum_next + SUM_W'(prod1_reg[j]);
        end
    end

    // Stage 3: quotient by reciprocal
    logic [SUM_W+RECIP_W-1:0] recip_prod;
    assign recip_prod = (SUM_W+RECIP_W)'(sum2_reg) * (SUM_W+RECIP_W)'(RECIP);

    // Stage 4: remainder mod 675, joined with the low bits
    logic [SUM_W-1:0] odd_rem;
    assign odd_rem = sum3_reg - SUM_W'(q3_reg * SUM_W'(DAY_ODD));

    // Stage 5: offset from start of schedule
    logic before_next;
    assign before_next = cur4_reg < base_reg;

    // Divider steps: restoring remainder, one bit per stage
    logic [ISEC_W-1:0] step_r [DIV_STAGES];
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            logic [ISEC_W:0] t;
            if (k == 0)
            begin
                t = {{ISEC_W{1'b0}}, d5_reg[DIV_STAGES-1]};
            end
            else
            begin
                t = {dr_reg[k-1], dd_reg[k-1][DIV_STAGES-1-k]};
            end
            if (t >= {1'b0, isec_reg})
            begin
                t = t - {1'b0, isec_reg};
            end
            step_r[k] = t[ISEC_W-1:0];
        end
    end

    // Final: pick the report point
    logic [ISEC_W-1:0] cand;
    logic [ISEC_W:0]   reach;
    logic [REM_W:0]    wrap;
    logic [REM_W-1:0]  rem_next;
    localparam int L = DIV_STAGES - 1;
    always_comb
    begin
        cand  = isec_reg - dr_reg[L];
        reach = (ISEC_W+1)'(dcur_reg[L]) + (ISEC_W+1)'(cand);
        wrap  = (REM_W+1)'(base_reg) + (REM_W+1)'(SECS_PER_DAY) - (REM_W+1)'(dcur_reg[L]);
        if (derr_reg[L])
        begin
            rem_next = '0;
        end
        else if (dbefore_reg[L])
        begin
            rem_next = base_reg - dcur_reg[L];
        end
        else if (reach < (ISEC_W+1)'(SECS_PER_DAY))
        begin
            rem_next = cand[REM_W-1:0];
        end
        else
        begin
            rem_next = wrap[REM_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            dv_reg[0] <= v5_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            ov_reg <= dv_reg[L];
        end
    end

    // Payloads; the config error joins at stage 5, where the derived values settle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err1_reg  <= req.ts_secs[TS_W-1];
            lo1_reg   <= req.ts_secs[LOW_BITS-1:0];
            prod1_reg <= prod_next;

            err2_reg <= err1_reg;
            lo2_reg  <= lo1_reg;
            sum2_reg <= sum_next;

            err3_reg <= err2_reg;
            lo3_reg  <= lo2_reg;
            sum3_reg <= sum2_reg;
            q3_reg   <= recip_prod[RECIP_SHIFT +: Q_W];

            err4_reg <= err3_reg;
            cur4_reg <= {odd_rem[ODD_W-1:0], lo3_reg};

            err5_reg    <= err4_reg || cfg_err_reg;
            cur5_reg    <= cur4_reg;
            before5_reg <= before_next;
            d5_reg      <= cur4_reg - base_reg;

            derr_reg[0]    <= err5_reg;
            dcur_reg[0]    <= cur5_reg;
            dbefore_reg[0] <= before5_reg;
            dd_reg[0]      <= d5_reg;
            dr_reg[0]      <= step_r[0];
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                derr_reg[k]    <= derr_reg[k-1];
                dcur_reg[k]    <= dcur_reg[k-1];
                dbefore_reg[k] <= dbefore_reg[k-1];
                dd_reg[k]      <= dd_reg[k-1];
                dr_reg[k]      <= step_r[k];
            end

            orem_reg <= rem_next;
            oerr_reg <= derr_reg[L];
        end
    end

    assign rsp.valid      = ov_reg;
    assign rsp.delay_secs = orem_reg;
    assign rsp.error      = oerr_reg;

endmodule

@@ tb/next_report_delay_calc_tb.sv @@
module next_report_delay_calc_tb;
    import nrdc_pkg::*;

    localparam int LATENCY   = 22;
    localparam int WD_LIMIT  = 2000;
    localparam int N_RANDOM  = 930;

    typedef struct packed {
        logic [REM_W-1:0] delay_secs;
        logic             error;
    } delay_result_t;

    // Directed row: timestamp, plus optional typed-in expectation
    typedef struct {
        logic [TS_W-1:0]  ts;
        bit               fixed;
        logic [REM_W-1:0] rem;
        logic             err;
    } ts_row_t;

    logic clk;
    logic rst_n;

    nrdc_cfg_if cfg ();
    nrdc_req_if req ();
    nrdc_rsp_if rsp ();

    next_report_delay_calc i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .req   (req.source),
        .rsp   (rsp.sink)
    );

    // Local copy of the registers
    logic [CHARS_W-1:0] start_chars;
    logic [IVL_W-1:0]   ivl_min;

    delay_result_t expected_delays[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  quiet_mode;
    bit  long_hold;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Predict the delay to the next report point
    function automatic delay_result_t predict_delay(input logic [TS_W-1:0] ts);
        delay_result_t r;
        int unsigned   dig[4];
        bit            ok;
        int unsigned   hh, mm, base, isec, cur, n;
        longint unsigned nxt;
        logic [7:0]    c;
        ok = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            c = start_chars[31-8*k -: 8];
            if (c < ASCII_ZERO || c > ASCII_NINE)
                ok = 1'b0;
            dig[k] = 32'(c - ASCII_ZERO);
        end
        if (ivl_min == 0 || ts[TS_W-1])
            ok = 1'b0;
        hh = dig[0] * 10 + dig[1];
        mm = dig[2] * 10 + dig[3];
        if (ok && (hh > MAX_HOUR || mm > MAX_MINUTE))
            ok = 1'b0;
        r.error = !ok;
        r.delay_secs = '0;
        if (ok)
        begin
            base = hh * SECS_PER_HOUR + mm * SECS_PER_MIN;
            isec = ivl_min * SECS_PER_MIN;
            cur  = int'(ts % SECS_PER_DAY);
            if (cur < base)
                r.delay_secs = REM_W'(base - cur);
            else
            begin
                n   = (cur - base) / isec;
                nxt = longint'(base) + longint'(n + 1) * longint'(isec);
                if (nxt < SECS_PER_DAY)
                    r.delay_secs = REM_W'(nxt - cur);
                else
                    r.delay_secs = REM_W'(base + SECS_PER_DAY - cur);
            end
        end
        return r;
    endfunction

    function automatic logic [TS_W-1:0] rand_ts();
        logic [TS_W-1:0] t;
        int unsigned     day;
        case ($urandom_range(0, 9))
            0:       t = {$urandom, $urandom};
            1:       t = {1'b0, 31'($urandom), $urandom};
            2:       t = 64'($urandom_range(0, 3 * SECS_PER_DAY));
            default:
            begin
                day = $urandom_range(0, 100000);
                t = 64'(day) * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
            end
        endcase
        return t;
    endfunction

    // Write one register; returns at a falling edge after the request is dropped
    task automatic write_reg(input cfg_idx_t idx, input logic [CHARS_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == CFG_START_TIME)
            start_chars = val;
        else if (idx == CFG_INTERVAL)
            ivl_min = val[IVL_W-1:0];
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Send one request; returns after it is accepted, at a falling edge
    task automatic send_ts(input logic [TS_W-1:0] ts, input bit idle_ok);
        int gap;
        if (idle_ok && !quiet_mode && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.ts_secs <= ts;
        do
            @(posedge clk);
        while (!req.ready);
        expected_delays.push_back(predict_delay(ts));
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (expected_delays.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        delay_result_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_delays.size() == 0)
            begin
                $error("unexpected result rem=%0d err=%0b", rsp.delay_secs, rsp.error);
                fail_count++;
            end
            else
            begin
                exp_r = expected_delays.pop_front();
                if (rsp.delay_secs !== exp_r.delay_secs)
                begin
                    $error("delay_secs: expected %0d, got %0d",
                           exp_r.delay_secs, rsp.delay_secs);
                    fail_count++;
                end
                if (rsp.error !== exp_r.error)
                begin
                    $error("error: expected %0b, got %0b", exp_r.error, rsp.error);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stalls in bursts; one long hold-off on request
    initial
    begin
        int n;
        bit hold_done;
        hold_done = 1'b0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_done)
            begin
                rsp.ready <= 1'b0;
                repeat (80) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet_mode && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n - 1) @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accept
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        ts_row_t rows[$];
        ts_row_t row;
        delay_result_t got;
        logic [CHARS_W-1:0] starts[6];
        logic [IVL_W-1:0]   ivls[6];
        quiet_mode  = 1'b0;
        long_hold   = 1'b0;
        start_chars = START_RESET;
        ivl_min     = IVL_RESET;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.ts_secs = '0;
        cfg.valid   = 1'b0;
        cfg.index   = CFG_START_TIME;
        cfg.data    = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows at reset config ("0000", 1 minute)
        rows.push_back('{64'd0, 1'b1, 17'd60, 1'b0});
        rows.push_back('{64'd59, 1'b1, 17'd1, 1'b0});
        rows.push_back('{64'd86399, 1'b1, 17'd1, 1'b0});
        rows.push_back('{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b0});
        rows.push_back('{64'h8000_0000_0000_0000, 1'b1, 17'd0, 1'b1});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 17'd0, 1'b1});
        rows.push_back('{64'hAAAA_AAAA_5555_5555, 1'b0, '0, 1'b0});
        rows.push_back('{64'h5555_5555_AAAA_AAAA, 1'b0, '0, 1'b0});
        foreach (rows[i])
        begin
            row = rows[i];
            send_ts(row.ts, 1'b0);
            if (row.fixed)
            begin
                got.delay_secs = row.rem;
                got.error      = row.err;
                expected_delays[$] = got;
            end
        end
        drain();

        // "2359", max interval: wrap past midnight, and before start
        write_reg(CFG_START_TIME, "2359");
        write_reg(CFG_INTERVAL, 16'hFFFF);
        send_ts(64'd0, 1'b0);
        send_ts(64'd86340, 1'b0);
        send_ts(64'd86399, 1'b0);
        drain();
        // Zero interval error, then hour and minute range, then bad digits
        write_reg(CFG_INTERVAL, 16'd0);
        send_ts(64'd100, 1'b0);
        drain();
        write_reg(CFG_INTERVAL, 16'd7);
        write_reg(CFG_START_TIME, "2400");
        send_ts(64'd100, 1'b0);
        drain();
        write_reg(CFG_START_TIME, "1260");
        send_ts(64'd100, 1'b0);
        drain();
        write_reg(CFG_START_TIME, "1a30");
        send_ts(64'd100, 1'b0);
        drain();
        write_reg(CFG_START_TIME, 32'h2F3A_3030);
        send_ts(64'd100, 1'b0);
        drain();
        write_reg(CFG_START_TIME, "0815");
        send_ts(64'd29700, 1'b0);
        send_ts(64'd29700 + 420, 1'b0);
        send_ts(64'd29699, 1'b0);
        drain();

        // Random phases through several settings
        starts = '{"0000", "2359", "1230", "0607", "9999", "2345"};
        ivls   = '{16'd1, 16'd15, 16'd0, 16'd1439, 16'hFFFF, 16'd60};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_START_TIME, ($urandom_range(0, 7) == 0) ? $urandom : starts[p]);
            write_reg(CFG_INTERVAL, ivls[p]);
            if (p == 5)
                quiet_mode = 1'b1;
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                if (p == 1 && i == 20)
                    long_hold = 1'b1;
                send_ts(rand_ts(), 1'b1);
            end
            drain();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
